// ----- hdl/dstfp_pkg.sv -----
// ----------------------------------------------------------------------------
// dstfp_pkg
// Shared constants, types and the power-of-ten table for the decimal
// string to fixed point converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dstfp_pkg;

	// number format
	localparam int FRAC_BITS       = 16;
	localparam int INT_BITS        = 31;
	localparam int MAX_FRAC_DIGITS = 9;
	localparam int VALUE_W         = 48;

	// fraction accumulator holds up to nine decimal digits
	localparam int FRAC_W = 30;
	localparam int NDIG_W = 4;
	localparam int CNT_W  = $clog2(FRAC_BITS + 1);

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		STOP_TERM  = 2'd0,
		STOP_DOT   = 2'd1,
		STOP_OTHER = 2'd2
	} stop_reason_t;

	// finished parse handed from the parser to the back end
	typedef struct packed {
		logic [INT_BITS-1:0] int_part;
		logic [FRAC_W-1:0]   frac;
		logic [NDIG_W-1:0]   ndig;
		logic                neg;
		logic                sat;
		stop_reason_t        reason;
	} fin_t;

	function automatic logic [FRAC_W-1:0] pow10(input logic [NDIG_W-1:0] n);
		logic [FRAC_W-1:0] p;
		unique case (n)
			4'd0:    p = 30'd1;
			4'd1:    p = 30'd10;
			4'd2:    p = 30'd100;
			4'd3:    p = 30'd1000;
			4'd4:    p = 30'd10000;
			4'd5:    p = 30'd100000;
			4'd6:    p = 30'd1000000;
			4'd7:    p = 30'd10000000;
			4'd8:    p = 30'd100000000;
			4'd9:    p = 30'd1000000000;
			default: p = 30'd1;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/dstfp_parse.sv -----
// ----------------------------------------------------------------------------
// dstfp_parse
// Character parser: sign, integer and fraction digit accumulation, stop
// detection and skip-to-terminator handling.
// ----------------------------------------------------------------------------
`default_nettype none

module dstfp_parse import dstfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] ch,
	output logic            fin_valid,
	output fin_t            fin
);

	localparam int IW4 = INT_BITS + 4;
	localparam int FW4 = FRAC_W + 4;
	localparam logic [INT_BITS-1:0] INT_MAX = '1;

	logic [INT_BITS-1:0] int_q;
	logic [FRAC_W-1:0]   frac_q;
	logic [NDIG_W-1:0]   ndig_q;
	logic                neg_q;
	logic                in_frac_q;
	logic                start_q;
	logic                skip_q;
	logic                ovf_q;

	logic                is_digit;
	logic [3:0]          dig;
	logic [IW4-1:0]      int_next;
	logic [FW4-1:0]      frac_next;
	logic                int_over;
	logic                sign_first;
	logic                dot_first;
	logic                stop;

	assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
	assign dig       = ch[3:0];
	assign int_next  = (IW4'(int_q) << 3) + (IW4'(int_q) << 1) + IW4'(dig);
	assign frac_next = (FW4'(frac_q) << 3) + (FW4'(frac_q) << 1) + FW4'(dig);
	assign int_over  = ovf_q || (int_next > IW4'(INT_MAX));

	assign sign_first = start_q && ((ch == CH_MINUS) || (ch == CH_PLUS));
	assign dot_first  = (ch == CH_DOT) && !in_frac_q;
	assign stop       = !skip_q && !sign_first && !is_digit && !dot_first;
	assign fin_valid  = take && stop;

	always_comb begin
		fin.int_part = int_q;
		fin.frac     = frac_q;
		fin.ndig     = ndig_q;
		fin.neg      = neg_q;
		fin.sat      = ovf_q;
		if (ch == CH_NUL) begin
			fin.reason = STOP_TERM;
		end else if (ch == CH_DOT) begin
			fin.reason = STOP_DOT;
		end else begin
			fin.reason = STOP_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q     <= '0;
			frac_q    <= '0;
			ndig_q    <= '0;
			neg_q     <= 1'b0;
			in_frac_q <= 1'b0;
			start_q   <= 1'b1;
			skip_q    <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (take) begin
			if (skip_q) begin
				if (ch == CH_NUL) begin
					skip_q  <= 1'b0;
					start_q <= 1'b1;
				end
			end else if (stop) begin
				// clear for the next number
				int_q     <= '0;
				frac_q    <= '0;
				ndig_q    <= '0;
				neg_q     <= 1'b0;
				in_frac_q <= 1'b0;
				start_q   <= 1'b1;
				ovf_q     <= 1'b0;
				skip_q    <= (ch != CH_NUL);
			end else begin
				start_q <= 1'b0;
				if (sign_first) begin
					neg_q <= (ch == CH_MINUS);
				end else if (is_digit) begin
					if (in_frac_q) begin
						if (ndig_q < NDIG_W'(MAX_FRAC_DIGITS)) begin
							frac_q <= frac_next[FRAC_W-1:0];
							ndig_q <= ndig_q + NDIG_W'(1);
						end
					end else if (int_over) begin
						int_q <= INT_MAX;
						ovf_q <= 1'b1;
					end else begin
						int_q <= int_next[INT_BITS-1:0];
					end
				end else begin
					in_frac_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dstfp_div.sv -----
// ----------------------------------------------------------------------------
// dstfp_div
// Bit-serial restoring divider: (frac << FRAC_BITS) / 10^n, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dstfp_div import dstfp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [FRAC_W-1:0]    num,
	input  wire logic [NDIG_W-1:0]    ndig,
	output logic                      busy,
	output logic [FRAC_BITS-1:0]      quot
);

	logic [FRAC_W-1:0]    rem_q;
	logic [FRAC_W-1:0]    den_q;
	logic [FRAC_BITS-1:0] quot_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [FRAC_W:0]      rem2;
	logic [FRAC_W:0]      diff;
	logic                 ge;

	// remainder stays below the divisor, so twice it fits one extra bit
	assign rem2 = {rem_q, 1'b0};
	assign diff = rem2 - {1'b0, den_q};
	assign ge   = rem2 >= {1'b0, den_q};

	assign busy = (cnt_q != '0);
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
		end else if (start) begin
			rem_q  <= num;
			den_q  <= pow10(ndig);
			quot_q <= '0;
			cnt_q  <= CNT_W'(FRAC_BITS);
		end else if (busy) begin
			rem_q  <= ge ? diff[FRAC_W-1:0] : rem2[FRAC_W-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], ge};
			cnt_q  <= cnt_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ----- hdl/decimal_string_to_fixed_point.sv -----
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point
// ASCII decimal string to signed fixed point converter, one character per
// word in, one fixed point result word out per parsed number.
// ----------------------------------------------------------------------------
// Takes a string one character per word on the ch channel and returns one
// result word per number on the res channel: value in two's complement with
// FRAC_BITS fraction bits (fraction truncated toward zero, sign applied
// after), saturated when the integer part clamped, and stop_reason telling
// whether a terminator, a second dot or another character ended the number.
// Sign, digit and dot characters are taken without holding off the input. A
// character that ends the number holds off the input while the fraction is
// divided by 10^n in a bit-serial restoring divider that produces one
// quotient bit per cycle, then while the result is handed off and loaded
// into the output register. A number with no fraction digits skips the
// divider and holds off the input only while the output register is loaded.
// Either wait grows while a result word still held in the output register
// is stalled. After an early stop the characters up to the next terminator
// are swallowed without a result.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_string_to_fixed_point import dstfp_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// character input
	input  wire logic                      ch_valid,
	output logic                           ch_stall,
	input  wire logic [7:0]                ch,
	// result output
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic signed [VALUE_W-1:0]      value,
	output logic                           saturated,
	output logic [1:0]                     stop_reason
);

	localparam int MAG_W = INT_BITS + FRAC_BITS;
	localparam int CMP_W = (MAG_W > VALUE_W) ? MAG_W : VALUE_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	state_t               state_q;
	fin_t                 job_q;
	logic                 res_valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 saturated_q;
	stop_reason_t         stop_reason_q;

	logic                 take;
	logic                 fin_valid;
	fin_t                 fin;
	logic                 div_start;
	logic                 div_busy;
	logic [FRAC_BITS-1:0] quot;

	// assembled result
	logic [FRAC_BITS-1:0] frac_fix;
	logic [CMP_W-1:0]     mag;
	logic                 mag_over;
	logic [VALUE_W-1:0]   mag_clamp;
	logic [VALUE_W-1:0]   value_next;
	logic                 load_out;

	// characters are taken only while no number is being finished
	assign ch_stall = (state_q != S_IDLE);
	assign take     = ch_valid && !ch_stall;

	dstfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.ch        (ch),
		.fin_valid (fin_valid),
		.fin       (fin)
	);

	// no fraction digits means a zero fraction, so the divider is skipped
	assign div_start = fin_valid && (fin.ndig != '0);

	dstfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (fin.frac),
		.ndig   (fin.ndig),
		.busy   (div_busy),
		.quot   (quot)
	);

	// quotient stays below 2^FRAC_BITS, so the add is a concatenation
	assign frac_fix = (job_q.ndig != '0) ? quot : '0;
	assign mag      = CMP_W'({job_q.int_part, frac_fix});
	assign mag_over = |mag[CMP_W-1:VALUE_W-1];

	always_comb begin
		if (mag_over) begin
			mag_clamp = {1'b0, {(VALUE_W-1){1'b1}}};
		end else begin
			mag_clamp = {1'b0, mag[VALUE_W-2:0]};
		end
		value_next = job_q.neg ? (VALUE_W'(0) - mag_clamp) : mag_clamp;
	end

	// output register frees the input side while a result waits
	assign load_out = (state_q == S_OUT) && (!res_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			job_q         <= '0;
			res_valid_q   <= 1'b0;
			value_q       <= '0;
			saturated_q   <= 1'b0;
			stop_reason_q <= STOP_TERM;
		end else begin
			// a new word replaces the one leaving in the same cycle
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fin_valid) begin
						job_q   <= fin;
						state_q <= div_start ? S_DIV : S_OUT;
					end
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (load_out) begin
						value_q       <= value_next;
						saturated_q   <= job_q.sat || mag_over;
						stop_reason_q <= job_q.reason;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid   = res_valid_q;
	assign value       = value_q;
	assign saturated   = saturated_q;
	assign stop_reason = stop_reason_q;

endmodule

`default_nettype wire

// ----- tb/decimal_string_to_fixed_point_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point_tb
// Self-checking testbench for the ASCII decimal to fixed point converter.
// ----------------------------------------------------------------------------
// Characters are driven one word at a time on the ch channel. Each accepted
// character goes through a parse model kept in this file, and every number
// that the model closes is queued as an expected result word. A checker pops
// that queue on every accepted result word and compares all fields. Stimulus
// is a short directed set of strings, then random strings (mostly well formed,
// some noise and broken strings) under several sender/receiver idling mixes,
// and a long receiver hold-off that fills the block while the sender keeps
// offering characters.
// ----------------------------------------------------------------------------

module decimal_string_to_fixed_point_tb;
	import dstfp_pkg::*;

	localparam longint unsigned INT_MAX = (64'd1 << INT_BITS) - 1;
	localparam longint unsigned MAG_MAX = (64'd1 << (VALUE_W - 1)) - 1;
	// worst terminating character: divider plus hand-off, with margin
	localparam int DRAIN_CYCLES = FRAC_BITS + 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 3000;

	// one expected result word
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               sat;
		stop_reason_t       reason;
	} number_t;

	logic clk;
	logic arst_n;
	logic ch_valid;
	logic ch_stall;
	logic [7:0] ch;
	logic res_valid;
	logic res_stall = 1'b0;
	logic signed [VALUE_W-1:0] value;
	logic saturated;
	logic [1:0] stop_reason;

	decimal_string_to_fixed_point dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.ch_valid    (ch_valid),
		.ch_stall    (ch_stall),
		.ch          (ch),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.value       (value),
		.saturated   (saturated),
		.stop_reason (stop_reason)
	);

	// parse model state, mirrors what the block holds between characters
	longint unsigned num_int;
	longint unsigned num_frac;
	int unsigned     num_ndig;
	bit              num_neg;
	bit              num_in_frac;
	bit              num_first = 1'b1;
	bit              num_skip;
	bit              num_ovf;

	number_t pending_numbers[$];

	int unsigned mismatches;
	int unsigned chars_sent;
	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned hold_seq;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// parse model
	// ------------------------------------------------------------------

	function automatic void clear_number();
		num_int     = 0;
		num_frac    = 0;
		num_ndig    = 0;
		num_neg     = 1'b0;
		num_in_frac = 1'b0;
		num_first   = 1'b1;
		num_ovf     = 1'b0;
	endfunction

	// closes the current number and queues the word it should produce
	function automatic void close_number(stop_reason_t why);
		longint unsigned scale;
		longint unsigned frac_fixed;
		longint unsigned mag;
		number_t n;
		scale      = 1;
		frac_fixed = 0;
		n.sat      = num_ovf;
		for (int i = 0; i < num_ndig; i++)
			scale = scale * 10;
		// fraction truncated toward zero before the sign goes on
		if (num_ndig != 0)
			frac_fixed = (num_frac << FRAC_BITS) / scale;
		mag = (num_int << FRAC_BITS) + frac_fixed;
		if (mag > MAG_MAX) begin
			mag   = MAG_MAX;
			n.sat = 1'b1;
		end
		n.value  = num_neg ? VALUE_W'(~mag + 64'd1) : VALUE_W'(mag);
		n.reason = why;
		pending_numbers.push_back(n);
	endfunction

	function automatic void parse_char(logic [7:0] c);
		longint unsigned d;
		longint unsigned nxt;
		// after an early stop everything up to the terminator is dropped
		if (num_skip) begin
			if (c == CH_NUL) begin
				num_skip = 1'b0;
				clear_number();
			end
			return;
		end
		// a sign only counts as the very first character
		if (num_first) begin
			num_first = 1'b0;
			if (c == CH_MINUS) begin
				num_neg = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (c >= CH_0 && c <= CH_9) begin
			d = longint'(c - CH_0);
			if (num_in_frac) begin
				// digits past the kept count are ignored
				if (num_ndig < MAX_FRAC_DIGITS) begin
					num_frac = num_frac * 10 + d;
					num_ndig++;
				end
			end else begin
				nxt = num_int * 10 + d;
				if (num_ovf || nxt > INT_MAX) begin
					num_int = INT_MAX;
					num_ovf = 1'b1;
				end else begin
					num_int = nxt;
				end
			end
			return;
		end
		if (c == CH_DOT && !num_in_frac) begin
			num_in_frac = 1'b1;
			return;
		end
		if (c == CH_NUL) begin
			close_number(STOP_TERM);
			clear_number();
			return;
		end
		close_number(c == CH_DOT ? STOP_DOT : STOP_OTHER);
		clear_number();
		num_skip = 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	// every accepted result word is held against the oldest expected number
	always @(posedge clk) begin
		number_t n;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_numbers.size() == 0) begin
				report_mismatch($sformatf("result word %0d with nothing expected", value));
			end else begin
				n = pending_numbers.pop_front();
				if (value !== n.value)
					report_mismatch($sformatf("value %0d, expected %0d",
						value, $signed(n.value)));
				if (saturated !== n.sat)
					report_mismatch($sformatf("saturated %b, expected %b",
						saturated, n.sat));
				if (stop_reason !== n.reason)
					report_mismatch($sformatf("stop_reason %0d, expected %0d",
						stop_reason, n.reason));
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver stall: random, or held high for a stretch on request
	// ------------------------------------------------------------------

	always @(negedge clk) begin
		if (hold_seen != hold_seq) begin
			hold_seen = hold_seq;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog: too long without any word moving on either channel
	always @(posedge clk) begin
		if ((ch_valid && !ch_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sender
	// ------------------------------------------------------------------

	// offers one character word, with random idle cycles in front of it
	task automatic send_char(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			ch_valid <= 1'b0;
			ch       <= 8'($urandom);
			@(negedge clk);
		end
		ch_valid <= 1'b1;
		ch       <= c;
		do
			@(posedge clk);
		while (ch_stall);
		parse_char(c);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic send_digits(input int unsigned n);
		repeat (n)
			send_char(CH_0 + 8'($urandom_range(9)));
	endtask

	// stops offering and waits until every expected number has come out,
	// then lets the block settle
	task automatic wait_drain();
		@(negedge clk);
		ch_valid <= 1'b0;
		while (pending_numbers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// one random string: mostly well formed, some noise and early stops
	task automatic send_random_string();
		int unsigned kind;
		int unsigned ending;
		logic [7:0]  c;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// raw noise, any byte value
			repeat ($urandom_range(6, 1))
				send_char(8'($urandom));
			return;
		end
		if ($urandom_range(2) == 1)
			send_char(CH_MINUS);
		else if ($urandom_range(1) == 1)
			send_char(CH_PLUS);
		if (kind < 12) begin
			// right at the integer clamp boundary
			send_text("214748364");
			send_digits(1);
		end else if (kind < 20) begin
			send_digits($urandom_range(12, 10));
		end else begin
			send_digits($urandom_range(6));
		end
		if ($urandom_range(99) < 70) begin
			send_char(CH_DOT);
			if ($urandom_range(9) == 0)
				send_digits($urandom_range(12, 8));
			else
				send_digits($urandom_range(4));
		end
		ending = $urandom_range(99);
		if (ending < 80) begin
			send_char(CH_NUL);
		end else begin
			if (ending < 90) begin
				send_char(CH_DOT);
			end else begin
				do
					c = 8'($urandom);
				while (c == CH_NUL || c == CH_DOT || (c >= CH_0 && c <= CH_9));
				send_char(c);
			end
			// junk that an early stop must swallow
			repeat ($urandom_range(3))
				send_char(8'($urandom_range(255, 1)));
			send_char(CH_NUL);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		// empty string
		send_char(CH_NUL);
		// lone sign
		send_char(CH_MINUS);
		send_char(CH_NUL);
		// negative, integer clamp and too many fraction digits at once
		send_text("-2147483648.1234567891");
		send_char(CH_NUL);
		// second decimal point, then the terminator rearms
		send_text("+1.2.");
		send_char(CH_NUL);
		// sign not first, high byte values skipped until the terminator
		send_text("7+");
		send_char(8'h80);
		send_char(8'hFF);
		send_char(CH_NUL);
		wait_drain();
	endtask

	task automatic test_random(input int unsigned sender_idle,
	                           input int unsigned receiver_stall,
	                           input int unsigned n_chars);
		int unsigned stop_at;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		stop_at   = chars_sent + n_chars;
		while (chars_sent < stop_at)
			send_random_string();
		// leave any half-parsed number closed before the next phase
		send_char(CH_NUL);
		wait_drain();
	endtask

	// receiver holds off while the sender keeps pushing short numbers
	task automatic test_backpressure();
		int unsigned stop_at;
		idle_pct  = 0;
		stall_pct = 0;
		stop_at   = chars_sent + 80;
		hold_seq++;
		while (chars_sent < stop_at) begin
			send_digits($urandom_range(2));
			send_char(CH_NUL);
		end
		// sender pauses until the block has handed everything back
		wait_drain();
	endtask

	initial begin
		arst_n    = 1'b0;
		ch_valid  = 1'b0;
		ch        = 8'h00;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 0, 320);
		test_random(45, 0, 320);
		test_random(0, 45, 320);
		test_backpressure();
		test_random(38, 38, 320);
		wait_drain();

		if (mismatches == 0 && pending_numbers.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
hdl/dstfp_pkg.sv
hdl/dstfp_parse.sv
hdl/dstfp_div.sv
hdl/decimal_string_to_fixed_point.sv
tb/decimal_string_to_fixed_point_tb.sv
